// File: hdl/bsc_pkg.sv
// Package for the bitmask sprite collision block.
// Holds op codes, word types and parameter defaults; no dependencies.
package bsc_pkg;

	localparam int CHUNK_BITS = 32;
	localparam int SHAMT_W = 5;

	localparam int DEF_SPRITES = 16;
	localparam int DEF_ROWS = 64;
	localparam int DEF_CHUNKS = 2;

	typedef logic [CHUNK_BITS-1:0] word_t;
	typedef logic [SHAMT_W-1:0] shamt_t;
	typedef logic [1:0] op_t;

	localparam op_t OP_CLEAR = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_CHECK = 2'd2;

	localparam word_t TOP_BIT = 32'h8000_0000;

endpackage

// File: hdl/bitmask_sprite_collision_top.sv
// Top level of the bitmask sprite collision block: sequencer, mask and bound memories.
// Depends on bsc_pkg, bsc_ram and bsc_match.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  item in  | start, busy      | op sprite_a pos_a_x pos_a_y pixel sprite_b
//           |                  | pos_b_x pos_b_y
//  result   | done (strobe)    | hit
//  config   | cfg_we           | cfg_wdata (transparent color)
//
// Write: a read, then a write-back. Clear: the sprite's mask words swept, one per cycle.
// Check: bound read, then per chunk pair a chunk test and a row walk, one row pair
// a cycle through the two read ports of the mask memory; stops early on a hit.
// After reset a pass over every mask word zeroes both memories, busy high.
// The result strobe is never held off; busy drops in the cycle the strobe shows.
module bitmask_sprite_collision_top #(
	parameter int SPRITES = bsc_pkg::DEF_SPRITES,
	parameter int ROWS = bsc_pkg::DEF_ROWS,
	parameter int CHUNKS = bsc_pkg::DEF_CHUNKS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bsc_pkg::op_t       op,
	input  logic [3:0]         sprite_a,
	input  logic signed [15:0] pos_a_x,
	input  logic signed [15:0] pos_a_y,
	input  logic [31:0]        pixel,
	input  logic [3:0]         sprite_b,
	input  logic signed [15:0] pos_b_x,
	input  logic signed [15:0] pos_b_y,
	output logic               done,
	output logic               hit,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);
	import bsc_pkg::*;

	localparam int SW = (SPRITES > 1) ? $clog2(SPRITES) : 1;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int DEPTH = SPRITES * ROWS * CHUNKS;
	localparam int SPAN = ROWS * CHUNKS;
	localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MTW = CW + RW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_CLR = 4'd2;
	localparam logic [3:0] ST_WR_RD = 4'd3;
	localparam logic [3:0] ST_WR_WB = 4'd4;
	localparam logic [3:0] ST_CK_META = 4'd5;
	localparam logic [3:0] ST_CK_LAT = 4'd6;
	localparam logic [3:0] ST_CK_CHUNK = 4'd7;
	localparam logic [3:0] ST_CK_ROW = 4'd8;

	logic [3:0] state_q;
	logic [MAW-1:0] cnt_q;
	logic [31:0] transparent_color_q;
	logic done_q;
	logic hit_q;

	logic [SW-1:0] spr_a_q;
	logic [SW-1:0] spr_b_q;
	logic [RW-1:0] wr_row_q;
	logic [CW-1:0] wr_chunk_q;
	shamt_t wr_bit_q;

	logic [10:0] c1_q, c2_q;
	shamt_t sh1_q, sh2_q;
	logic [15:0] dy1_q, dy2_q;
	logic [15:0] r1_q, r2_q;
	logic [CW-1:0] hc_a_q, hc_b_q;
	logic [RW-1:0] lr_a_q, lr_b_q;
	logic pend_s1;

	// memory ports
	logic mwe;
	logic [MAW-1:0] mwaddr, mraddr_a, mraddr_b;
	word_t mwdata, mrdata_a, mrdata_b;
	logic twe;
	logic [SW-1:0] twaddr, traddr_a, traddr_b;
	logic [MTW-1:0] twdata, trdata_a, trdata_b;

	logic accept;
	logic [SW-1:0] in_sa, in_sb;
	logic sa_ok, sb_ok, wr_ok;
	logic signed [16:0] dx_ab, dx_ba, dy_ab, dy_ba;
	logic [31:0] in_ax32, in_ay32;
	logic [31:0] wr_addr32, rd_a32, rd_b32, clr_addr32;
	logic row_ok, chunk_ok, overlap;
	logic [CW-1:0] old_hc;
	logic [RW-1:0] old_lr;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign hit = hit_q;

	assign in_sa = SW'(32'(sprite_a));
	assign in_sb = SW'(32'(sprite_b));
	assign sa_ok = 32'(sprite_a) < 32'(SPRITES);
	assign sb_ok = 32'(sprite_b) < 32'(SPRITES);
	assign in_ax32 = {16'b0, pos_a_x};
	assign in_ay32 = {16'b0, pos_a_y};
	assign wr_ok = sa_ok && (pixel != transparent_color_q) && !pos_a_x[15] && !pos_a_y[15]
		&& (in_ax32 < 32'(CHUNKS * CHUNK_BITS)) && (in_ay32 < 32'(ROWS));

	assign dx_ab = 17'(pos_a_x) - 17'(pos_b_x);
	assign dx_ba = 17'(pos_b_x) - 17'(pos_a_x);
	assign dy_ab = 17'(pos_a_y) - 17'(pos_b_y);
	assign dy_ba = 17'(pos_b_y) - 17'(pos_a_y);

	assign wr_addr32 = (32'(spr_a_q) * 32'(ROWS) + 32'(wr_row_q)) * 32'(CHUNKS)
		+ 32'(wr_chunk_q);
	assign rd_a32 = (32'(spr_a_q) * 32'(ROWS) + 32'(r1_q[RW-1:0])) * 32'(CHUNKS)
		+ 32'(c1_q[CW-1:0]);
	assign rd_b32 = (32'(spr_b_q) * 32'(ROWS) + 32'(r2_q[RW-1:0])) * 32'(CHUNKS)
		+ 32'(c2_q[CW-1:0]);
	assign clr_addr32 = 32'(spr_a_q) * 32'(SPAN) + 32'(cnt_q);

	assign chunk_ok = (c1_q <= 11'(hc_a_q)) && (c2_q <= 11'(hc_b_q));
	assign row_ok = (r1_q <= 16'(lr_a_q)) && (r2_q <= 16'(lr_b_q));

	assign old_hc = trdata_a[MTW-1:RW];
	assign old_lr = trdata_a[RW-1:0];

	always_comb begin
		mwe = 1'b0;
		mwaddr = cnt_q;
		mwdata = '0;
		mraddr_a = wr_addr32[MAW-1:0];
		mraddr_b = rd_b32[MAW-1:0];
		twe = 1'b0;
		twaddr = spr_a_q;
		twdata = '0;
		traddr_a = spr_a_q;
		traddr_b = spr_b_q;
		case (state_q)
			ST_INIT: begin
				mwe = 1'b1;
				twe = (32'(cnt_q) < 32'(SPRITES));
				twaddr = SW'(32'(cnt_q));
			end
			ST_CLR: begin
				mwe = 1'b1;
				mwaddr = clr_addr32[MAW-1:0];
				twe = (cnt_q == '0);
			end
			ST_WR_WB: begin
				mwe = 1'b1;
				mwaddr = wr_addr32[MAW-1:0];
				mwdata = mrdata_a | (TOP_BIT >> wr_bit_q);
				twe = 1'b1;
				twdata = {(wr_chunk_q > old_hc) ? wr_chunk_q : old_hc,
					(wr_row_q > old_lr) ? wr_row_q : old_lr};
			end
			ST_CK_ROW: begin
				mraddr_a = rd_a32[MAW-1:0];
			end
			default: begin
			end
		endcase
	end

	bsc_ram #(.WIDTH(CHUNK_BITS), .DEPTH(DEPTH), .AW(MAW)) u_mask_ram (
		.clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
		.raddr_a(mraddr_a), .rdata_a(mrdata_a),
		.raddr_b(mraddr_b), .rdata_b(mrdata_b)
	);

	bsc_ram #(.WIDTH(MTW), .DEPTH(SPRITES), .AW(SW)) u_bound_ram (
		.clk(clk), .we(twe), .waddr(twaddr), .wdata(twdata),
		.raddr_a(traddr_a), .rdata_a(trdata_a),
		.raddr_b(traddr_b), .rdata_b(trdata_b)
	);

	bsc_match u_match (
		.word_a(mrdata_a), .word_b(mrdata_b),
		.sh_a(sh1_q), .sh_b(sh2_q), .overlap(overlap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_color_q <= '0;
		end else if (cfg_we) begin
			transparent_color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			hit_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (op)
							OP_CLEAR: begin
								if (sa_ok) state_q <= ST_CLR;
								else done_q <= 1'b1;
							end
							OP_WRITE: begin
								if (wr_ok) state_q <= ST_WR_RD;
								else done_q <= 1'b1;
							end
							OP_CHECK: begin
								if (sa_ok && sb_ok) state_q <= ST_CK_META;
								else done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == 32'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == 32'(SPAN - 1)) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_WB;
				end
				ST_WR_WB: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				ST_CK_META: begin
					state_q <= ST_CK_LAT;
				end
				ST_CK_LAT: begin
					state_q <= ST_CK_CHUNK;
				end
				ST_CK_CHUNK: begin
					pend_s1 <= 1'b0;
					if (chunk_ok) begin
						state_q <= ST_CK_ROW;
					end else begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				ST_CK_ROW: begin
					if (pend_s1 && overlap) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
						hit_q <= 1'b1;
						pend_s1 <= 1'b0;
					end else if (row_ok) begin
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						state_q <= ST_CK_CHUNK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			spr_a_q <= in_sa;
			spr_b_q <= in_sb;
			wr_row_q <= pos_a_y[RW-1:0];
			wr_chunk_q <= CW'(in_ax32 >> SHAMT_W);
			wr_bit_q <= pos_a_x[SHAMT_W-1:0];
			if (!dx_ab[16] && (dx_ab != '0)) begin
				c1_q <= '0;
				sh1_q <= '0;
				c2_q <= dx_ab[15:SHAMT_W];
				sh2_q <= dx_ab[SHAMT_W-1:0];
			end else begin
				c1_q <= dx_ba[15:SHAMT_W];
				sh1_q <= dx_ba[SHAMT_W-1:0];
				c2_q <= '0;
				sh2_q <= '0;
			end
			if (!dy_ab[16] && (dy_ab != '0)) begin
				dy1_q <= '0;
				dy2_q <= dy_ab[15:0];
			end else begin
				dy1_q <= dy_ba[15:0];
				dy2_q <= '0;
			end
		end
		if (state_q == ST_CK_LAT) begin
			hc_a_q <= trdata_a[MTW-1:RW];
			lr_a_q <= trdata_a[RW-1:0];
			hc_b_q <= trdata_b[MTW-1:RW];
			lr_b_q <= trdata_b[RW-1:0];
		end
		if (state_q == ST_CK_CHUNK) begin
			r1_q <= dy1_q;
			r2_q <= dy2_q;
		end
		if (state_q == ST_CK_ROW) begin
			if (!(pend_s1 && overlap)) begin
				if (row_ok) begin
					r1_q <= r1_q + 1'b1;
					r2_q <= r2_q + 1'b1;
				end else if (sh1_q == '0 && sh2_q == '0) begin
					c1_q <= c1_q + 1'b1;
					c2_q <= c2_q + 1'b1;
				end else if (sh1_q == '0) begin
					c2_q <= c2_q + 1'b1;
					sh1_q <= shamt_t'(~sh2_q + 1'b1);
					sh2_q <= '0;
				end else begin
					c1_q <= c1_q + 1'b1;
					sh2_q <= shamt_t'(~sh1_q + 1'b1);
					sh1_q <= '0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_hit_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit without result strobe");
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted item neither in work nor answered");
	a_no_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CK_ROW || state_q == ST_CK_CHUNK) |-> !mwe && !twe)
		else $error("memory written during a check");
	a_hit_from_row_compare: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> $past(state_q) == ST_CK_ROW)
		else $error("hit raised outside the row compare");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(accept))
		else $error("result strobe held without a new transfer");
`endif

endmodule

// File: hdl/bsc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module bsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hdl/bsc_match.sv
// Row compare for a collision check: aligns two mask words and tests overlap.
// Depends on bsc_pkg.
module bsc_match (
	input  bsc_pkg::word_t  word_a,
	input  bsc_pkg::word_t  word_b,
	input  bsc_pkg::shamt_t sh_a,
	input  bsc_pkg::shamt_t sh_b,
	output logic            overlap
);
	import bsc_pkg::*;

	word_t al_a;
	word_t al_b;

	assign al_a = word_a << sh_a;
	assign al_b = word_b << sh_b;
	assign overlap = |(al_a & al_b);

endmodule
